>>> rtl/spq_pkg.sv
// Shared types for the sorted priority queue: commands, status codes,
// cell operations and the entry and control records passed between cells.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int TAG_W  = 32;
	localparam int PRIO_W = 32;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int OUT_COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_PEEK   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_UPDATE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_MATCH  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_INSERT = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic                     occ;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
	} cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry, compares it against the
// broadcast command and shifts with its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int TW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t    left,
	input  logic               left_ge,
	input  spq_pkg::entry_t    right,
	input  logic               take_right,
	output spq_pkg::entry_t    ent,
	output logic               ge,
	output logic               match
);

	logic                               occ_q;
	logic                               match_q;
	logic [TW-1:0]                      tag_q;
	logic signed [spq_pkg::PRIO_W-1:0]  prio_q;

	// unoccupied slots count as "greater or equal" so the tail takes the new entry
	assign ge    = !occ_q || (prio_q >= ctrl.prio);
	assign match = match_q;
	assign ent   = '{occ: occ_q, tag: spq_pkg::TAG_W'(tag_q), prio: prio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (ctrl.op)
				spq_pkg::OP_MATCH: begin
					match_q <= occ_q && (tag_q == ctrl.tag[TW-1:0]);
				end
				spq_pkg::OP_REMOVE: begin
					if (take_right) begin
						occ_q <= right.occ;
					end
				end
				spq_pkg::OP_INSERT: begin
					if (left_ge) begin
						occ_q <= left.occ;
					end else if (ge) begin
						occ_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			spq_pkg::OP_REMOVE: begin
				if (take_right) begin
					tag_q  <= right.tag[TW-1:0];
					prio_q <= right.prio;
				end
			end
			spq_pkg::OP_INSERT: begin
				if (left_ge) begin
					tag_q  <= left.tag[TW-1:0];
					prio_q <= left.prio;
				end else if (ge) begin
					tag_q  <= ctrl.tag[TW-1:0];
					prio_q <= ctrl.prio;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/spq_prefix.sv
// Log-depth inclusive prefix OR over the cell match flags; marks every
// cell at or after the first match. No dependencies.
`timescale 1ns / 1ps

module spq_prefix #(
	parameter int N = 16
) (
	input  logic [N-1:0] bits,
	output logic [N-1:0] any_upto
);

	localparam int L = $clog2(N);

	logic [N-1:0] lvl [L+1];

	assign lvl[0]   = bits;
	assign any_upto = lvl[L];

	for (genvar k = 0; k < L; k++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << k)) begin : g_or
				assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
			end else begin : g_pass
				assign lvl[k+1][i] = lvl[k][i];
			end
		end
	end

endmodule

>>> rtl/sorted_priority_queue.sv
// Bounded min-priority queue kept sorted in a row of CAPACITY cells, slot 0
// being the head. One item is worked at a time. After the accepting edge, a
// peek goes straight to its report step, an insert does one compare-and-shift
// step across all cells, a remove a match step then a shift step, and an update
// match, shift and insert steps (insert skipped if the tag is not found). Remove
// or update on an empty queue goes straight to the report step. The next item
// is accepted at the earliest in the cycle after the result is loaded. The
// result register holds until taken while the next item is accepted and
// worked; that item then waits in its report step, with the input stalled,
// until the earlier result is taken.
// Depends on spq_pkg, spq_cell and spq_prefix.
`timescale 1ns / 1ps

module sorted_priority_queue #(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], value_tag[33:2], priority_req[65:34], zero[71:66]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], head_valid[2], head_tag[34:3], head_priority[66:35],
	// entry_count[71:67]
	output logic [71:0] m_tdata
);

	localparam int TW = (TAG_BITS < spq_pkg::TAG_W) ? TAG_BITS : spq_pkg::TAG_W;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MATCH  = 5'b00010,
		ST_REMOVE = 5'b00100,
		ST_INSERT = 5'b01000,
		ST_REPORT = 5'b10000
	} state_t;

	state_t                             state_q;
	spq_pkg::cmd_t                      cmd_q;
	spq_pkg::stat_t                     stat_q;
	logic [spq_pkg::TAG_W-1:0]          tag_q;
	logic signed [spq_pkg::PRIO_W-1:0]  prio_q;
	logic [CW-1:0]                      count_q;
	logic                               m_valid_q;
	logic [71:0]                        m_data_q;

	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     ent [CAPACITY];
	logic [CAPACITY-1:0] ge_v;
	logic [CAPACITY-1:0] match_v;
	logic [CAPACITY-1:0] pre_v;
	logic [CAPACITY-1:0] occ_v;
	logic                found;
	logic                full;
	logic                empty;
	logic                out_free;
	logic [CW+4:0]       count_ext;
	spq_pkg::cmd_t       in_cmd;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign found     = pre_v[CAPACITY-1];
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign out_free  = !m_valid_q || m_tready;
	assign count_ext = {5'b0, count_q};
	assign in_cmd    = spq_pkg::cmd_t'(s_tdata[1:0]);

	always_comb begin
		ctrl.tag  = tag_q;
		ctrl.prio = prio_q;
		case (state_q)
			ST_MATCH:  ctrl.op = spq_pkg::OP_MATCH;
			ST_REMOVE: ctrl.op = spq_pkg::OP_REMOVE;
			ST_INSERT: ctrl.op = full ? spq_pkg::OP_HOLD : spq_pkg::OP_INSERT;
			default:   ctrl.op = spq_pkg::OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_ge;

		if (i == 0) begin : g_first
			assign left_e  = '0;
			assign left_ge = 1'b0;
		end else begin : g_mid
			assign left_e  = ent[i-1];
			assign left_ge = ge_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = ent[i+1];
		end

		spq_cell #(
			.TW(TW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left      (left_e),
			.left_ge   (left_ge),
			.right     (right_e),
			.take_right(pre_v[i]),
			.ent       (ent[i]),
			.ge        (ge_v[i]),
			.match     (match_v[i])
		);

		assign occ_v[i] = ent[i].occ;
	end

	spq_prefix #(
		.N(CAPACITY)
	) u_prefix (
		.bits    (match_v),
		.any_upto(pre_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_REPORT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (in_cmd)
							spq_pkg::CMD_INSERT: state_q <= ST_INSERT;
							spq_pkg::CMD_PEEK:   state_q <= ST_REPORT;
							default:             state_q <= empty ? ST_REPORT : ST_MATCH;
						endcase
					end
				end
				ST_MATCH: begin
					state_q <= ST_REMOVE;
				end
				ST_REMOVE: begin
					if (found) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= (found && cmd_q == spq_pkg::CMD_UPDATE) ? ST_INSERT : ST_REPORT;
				end
				ST_INSERT: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd_q  <= in_cmd;
					tag_q  <= s_tdata[33:2] & spq_pkg::TAG_W'({TW{1'b1}});
					prio_q <= s_tdata[65:34];
					stat_q <= (in_cmd != spq_pkg::CMD_INSERT && empty) ?
						spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
				end
			end
			ST_REMOVE: begin
				if (!found) begin
					stat_q <= spq_pkg::STAT_NOT_FOUND;
				end
			end
			ST_INSERT: begin
				if (full) begin
					stat_q <= spq_pkg::STAT_FULL;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					m_data_q[1:0]   <= stat_q;
					m_data_q[2]     <= !empty;
					m_data_q[34:3]  <= empty ? '0 : ent[0].tag;
					m_data_q[66:35] <= empty ? '0 : ent[0].prio;
					m_data_q[71:67] <= count_ext[4:0];
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_v) == int'(count_q))
		else $error("cell occupancy disagrees with entry count");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		occ_v[1] |-> (occ_v[0] && ent[0].prio <= ent[1].prio))
		else $error("head pair out of order");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REMOVE && found) |=> count_q == $past(count_q) - 1'b1)
		else $error("removal did not shrink the queue");

	a_report_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented after report");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for sorted_priority_queue: drives commands on the
// input stream, mirrors the sorted queue in a checker class and compares results.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 16;
	localparam int RANDOM_PER_PHASE = 480;

	typedef struct packed {
		spq_pkg::stat_t                    status;
		logic                              head_valid;
		logic [spq_pkg::TAG_W-1:0]         head_tag;
		logic signed [spq_pkg::PRIO_W-1:0] head_prio;
		logic [spq_pkg::OUT_COUNT_W-1:0]   count;
	} answer_t;

	class sorted_queue_checker;
		logic [spq_pkg::TAG_W-1:0]         mirror_tag[DEPTH];
		logic signed [spq_pkg::PRIO_W-1:0] mirror_prio[DEPTH];
		int                                held;
		answer_t                           awaited_answers[$];
		int                                mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void place(logic [spq_pkg::TAG_W-1:0] tag,
				logic signed [spq_pkg::PRIO_W-1:0] prio);
			int pos;
			pos = 0;
			while (pos < held && mirror_prio[pos] < prio)
				pos++;
			for (int i = held; i > pos; i--) begin
				mirror_tag[i] = mirror_tag[i-1];
				mirror_prio[i] = mirror_prio[i-1];
			end
			mirror_tag[pos] = tag;
			mirror_prio[pos] = prio;
			held++;
		endfunction

		function spq_pkg::stat_t take(logic [spq_pkg::TAG_W-1:0] tag);
			int pos;
			pos = 0;
			if (held == 0)
				return spq_pkg::STAT_EMPTY;
			while (pos < held && mirror_tag[pos] != tag)
				pos++;
			if (pos >= held)
				return spq_pkg::STAT_NOT_FOUND;
			for (int i = pos; i + 1 < held; i++) begin
				mirror_tag[i] = mirror_tag[i+1];
				mirror_prio[i] = mirror_prio[i+1];
			end
			held--;
			return spq_pkg::STAT_OK;
		endfunction

		function void note_command(spq_pkg::cmd_t cmd, logic [spq_pkg::TAG_W-1:0] tag,
				logic signed [spq_pkg::PRIO_W-1:0] prio);
			answer_t a;
			a.status = spq_pkg::STAT_OK;
			case (cmd)
				spq_pkg::CMD_INSERT: begin
					if (held >= DEPTH)
						a.status = spq_pkg::STAT_FULL;
					else
						place(tag, prio);
				end
				spq_pkg::CMD_PEEK: begin
					if (held == 0)
						a.status = spq_pkg::STAT_EMPTY;
				end
				spq_pkg::CMD_REMOVE: a.status = take(tag);
				default: begin
					a.status = take(tag);
					if (a.status == spq_pkg::STAT_OK)
						place(tag, prio);
				end
			endcase
			a.head_valid = (held > 0);
			a.head_tag = (held > 0) ? mirror_tag[0] : '0;
			a.head_prio = (held > 0) ? mirror_prio[0] : '0;
			a.count = held[spq_pkg::OUT_COUNT_W-1:0];
			awaited_answers.push_back(a);
		endfunction

		function void check_result(logic [71:0] data);
			answer_t got, want;
			got.status = spq_pkg::stat_t'(data[1:0]);
			got.head_valid = data[2];
			got.head_tag = data[34:3];
			got.head_prio = data[66:35];
			got.count = data[71:67];
			if (awaited_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", data);
				return;
			end
			want = awaited_answers.pop_front();
			if (got.status !== want.status || got.head_valid !== want.head_valid ||
					got.head_tag !== want.head_tag || got.head_prio !== want.head_prio ||
					got.count !== want.count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp st=%0d hv=%0b tag=%h prio=%h cnt=%0d",
						want.status, want.head_valid, want.head_tag, want.head_prio,
						want.count);
					$display("          got st=%0d hv=%0b tag=%h prio=%h cnt=%0d",
						got.status, got.head_valid, got.head_tag, got.head_prio,
						got.count);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	sorted_queue_checker checker_h;
	int phase = -1;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [spq_pkg::TAG_W-1:0] tag_pool[8];

	sorted_priority_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_item(spq_pkg::cmd_t cmd, logic [spq_pkg::TAG_W-1:0] tag,
			logic signed [spq_pkg::PRIO_W-1:0] prio);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, prio, tag, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		checker_h.note_command(cmd, tag, prio);
	endtask

	function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_prio();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return spq_pkg::PRIO_W'($signed($urandom_range(4)) - 2) <<< 16;
		else if (r < 50)
			return ($urandom_range(1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
		else if (r < 70)
			return spq_pkg::PRIO_W'($signed($urandom_range(200)) - 100);
		return $urandom;
	endfunction

	function automatic logic [spq_pkg::TAG_W-1:0] pick_tag(bit from_queue);
		if (from_queue && checker_h.held > 0 && $urandom_range(99) < 75)
			return checker_h.mirror_tag[$urandom_range(checker_h.held - 1)];
		if ($urandom_range(99) < 80)
			return tag_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	task automatic send_random(int mode);
		int r;
		int w_ins, w_peek, w_rem;
		spq_pkg::cmd_t cmd;
		case (mode)
			0: begin w_ins = 60; w_peek = 10; w_rem = 15; end
			1: begin w_ins = 20; w_peek = 10; w_rem = 50; end
			default: begin w_ins = 35; w_peek = 15; w_rem = 25; end
		endcase
		r = $urandom_range(99);
		if (r < w_ins)
			cmd = spq_pkg::CMD_INSERT;
		else if (r < w_ins + w_peek)
			cmd = spq_pkg::CMD_PEEK;
		else if (r < w_ins + w_peek + w_rem)
			cmd = spq_pkg::CMD_REMOVE;
		else
			cmd = spq_pkg::CMD_UPDATE;
		send_item(cmd, pick_tag(cmd != spq_pkg::CMD_INSERT), pick_prio());
	endtask

	// receiver: random stalls, plus a long hold-off at the start of some phases
	initial begin
		int seen_phase;
		int hold_left;
		seen_phase = -1;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				checker_h.check_result(m_tdata);
			@(negedge clk);
			if (phase != seen_phase) begin
				seen_phase = phase;
				if (phase == 0 || phase == 3)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#5ms;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int send_pct[4];
		int recv_pct[4];
		int tail;
		send_pct = '{0, 47, 0, 23};
		recv_pct = '{0, 0, 47, 23};
		checker_h = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = $urandom;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// empty queue, extremes, ties, duplicates, absent tags
		send_item(spq_pkg::CMD_PEEK, 32'h0, 32'sh0);
		send_item(spq_pkg::CMD_REMOVE, 32'h5, 32'sh0);
		send_item(spq_pkg::CMD_UPDATE, 32'h5, 32'sh10000);
		send_item(spq_pkg::CMD_INSERT, 32'h0, 32'sh7FFFFFFF);
		send_item(spq_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'sh80000000);
		send_item(spq_pkg::CMD_INSERT, 32'h0, 32'sh0);
		send_item(spq_pkg::CMD_INSERT, 32'h5, 32'sh0);
		send_item(spq_pkg::CMD_PEEK, 32'h0, 32'sh0);
		send_item(spq_pkg::CMD_REMOVE, 32'h0, 32'sh0);
		send_item(spq_pkg::CMD_REMOVE, 32'h1234, 32'sh0);
		send_item(spq_pkg::CMD_UPDATE, 32'h1234, 32'sh0);
		send_item(spq_pkg::CMD_UPDATE, 32'hFFFFFFFF, 32'sh7FFFFFFF);
		send_item(spq_pkg::CMD_UPDATE, 32'h5, 32'sh80000000);
		send_item(spq_pkg::CMD_PEEK, 32'hAAAAAAAA, 32'sh55555555);
		send_item(spq_pkg::CMD_REMOVE, 32'h5, 32'sh0);
		send_item(spq_pkg::CMD_REMOVE, 32'h0, 32'sh0);
		send_item(spq_pkg::CMD_REMOVE, 32'hFFFFFFFF, 32'sh0);
		send_item(spq_pkg::CMD_PEEK, 32'h0, 32'sh0);

		for (int p = 0; p < 4; p++) begin
			phase = p;
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				send_random((i / 60) % 3);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (checker_h.awaited_answers.size() != 0)
			@(posedge clk);
		tail = 0;
		while (tail < 20) begin
			@(posedge clk);
			tail++;
		end
		if (checker_h.mismatches == 0 && checker_h.awaited_answers.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_prefix.sv
rtl/sorted_priority_queue.sv
sim/testbench.sv
